@@ hw/rtl/pqee_pkg.sv @@
// package for the perturbed quantization coefficient unit
// holds field types, the request structs and the binary gcd step helpers
`default_nettype none
package pqee_pkg;

    typedef logic [5:0]         freq_t;
    typedef logic signed [11:0] coef_t;
    typedef logic [7:0]         step_t;
    typedef logic [6:0]         modulus_t;

    typedef struct packed {
        freq_t freq_index;
        coef_t first_coef;
        step_t first_step;
        step_t second_step;
        logic  message_bit;
        coef_t received_coef;
    } in_req_t;

    typedef struct packed {
        logic     eligible;
        modulus_t pair_modulus;
        coef_t    embedded_coef;
        logic     bit_found;
        logic     found_bit;
        logic     ambiguous;
    } out_req_t;

    // shift out trailing zeros, zero stays zero
    function automatic logic [7:0] strip_twos(input logic [7:0] x_in);
        logic [7:0] x;
        x = x_in;
        for (int i = 0; i < 8; i++)
        begin
            if (x != 8'd0 && !x[0])
            begin
                x = {1'b0, x[7:1]};
            end
        end
        return x;
    endfunction

    // one binary gcd step on {a, b} with a odd; once b is zero a holds the gcd
    function automatic logic [15:0] gcd_step(input logic [15:0] ab_in);
        logic [7:0] a;
        logic [7:0] b;
        a = ab_in[15:8];
        b = ab_in[7:0];
        if (b != 8'd0)
        begin
            b = strip_twos(b);
            if (a > b)
            begin
                {a, b} = {b, a};
            end
            b = b - a;
        end
        return {a, b};
    endfunction

endpackage : pqee_pkg
`default_nettype wire

@@ hw/rtl/pqee_stream_if.sv @@
// valid/ready channel carrying one request of payload type T
// depends on nothing
`default_nettype none
interface pqee_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface : pqee_stream_if
`default_nettype wire

@@ hw/rtl/pqee_divider.sv @@
// pipelined restoring unsigned divider, BITS_PER quotient bits per stage
// numerator up to 20 bits by an 8-bit divisor; depends on nothing
`default_nettype none
module pqee_divider #(
    parameter int NUM_W    = 20,
    parameter int BITS_PER = 4,
    parameter int TAG_W    = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [7:0]       den,
    input  wire logic [TAG_W-1:0] in_tag,
    output logic                  out_valid,
    output logic [NUM_W-1:0]      quot,
    output logic [TAG_W-1:0]      out_tag
);
    localparam int STAGES = (NUM_W + BITS_PER - 1) / BITS_PER;
    localparam int TOT    = STAGES * BITS_PER;

    logic [TOT-1:0]   q_reg [STAGES+1];
    logic [8:0]       r_reg [STAGES];
    logic [7:0]       d_reg [STAGES];
    logic [TAG_W-1:0] t_reg [STAGES+1];
    logic             v_reg [STAGES+1];

    always_comb
    begin
        q_reg[0] = TOT'(num);
        r_reg[0] = 9'd0;
        d_reg[0] = den;
        t_reg[0] = in_tag;
        v_reg[0] = in_valid;
    end

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic [TOT-1:0]   q_next;
        logic [8:0]       r_next;
        logic [TOT-1:0]   q_s_reg;
        logic [TAG_W-1:0] t_s_reg;
        logic             v_s_reg;

        always_comb
        begin
            logic [9:0] trial;
            q_next = q_reg[s];
            r_next = r_reg[s];
            for (int b = 0; b < BITS_PER; b++)
            begin
                trial  = {r_next, q_next[TOT-1]};
                q_next = {q_next[TOT-2:0], 1'b0};
                if (trial >= {2'b00, d_reg[s]})
                begin
                    r_next    = 9'(trial - {2'b00, d_reg[s]});
                    q_next[0] = 1'b1;
                end
                else
                begin
                    r_next = trial[8:0];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_s_reg <= 1'b0;
            end
            else if (en)
            begin
                v_s_reg <= v_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_s_reg <= q_next;
                t_s_reg <= t_reg[s];
            end
        end

        always_comb
        begin
            q_reg[s+1] = q_s_reg;
            t_reg[s+1] = t_s_reg;
            v_reg[s+1] = v_s_reg;
        end

        if (s < STAGES - 1)
        begin : g_carry
            logic [8:0] r_s_reg;
            logic [7:0] d_s_reg;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_s_reg <= r_next;
                    d_s_reg <= d_reg[s];
                end
            end

            always_comb
            begin
                r_reg[s+1] = r_s_reg;
                d_reg[s+1] = d_s_reg;
            end
        end
    end

    assign out_valid = v_reg[STAGES];
    assign quot      = q_reg[STAGES][NUM_W-1:0];
    assign out_tag   = t_reg[STAGES];
endmodule : pqee_divider
`default_nettype wire

@@ hw/rtl/pq_coefficient_embed_extract_core.sv @@
// perturbed quantization embed and extract core, top level
// depends on pqee_pkg, pqee_stream_if and pqee_divider
// stages: range check, 5 gcd stages, 2 modulus divider stages,
// 3 half modulus divider stages, eligibility and product, 5 candidate divider stages, output
// throughput: one request per cycle; the whole pipeline holds while a result waits
// reset: asynchronous active low, clears all valid bits; no state beyond the pipeline
`default_nettype none
module pq_coefficient_embed_extract_core #(
    parameter int MAX_STEP = 120
) (
    input  wire logic clk,
    input  wire logic rst_n,
    pqee_stream_if.sink   in_ch,
    pqee_stream_if.source out_ch
);
    import pqee_pkg::*;

    localparam int NUM_W      = 20;
    localparam int GCD_STAGES = 5;
    localparam int GCD_ITERS  = 4;
    localparam int MTAG_W     = $bits(in_req_t) + 13;
    localparam int HTAG_W     = $bits(in_req_t) + 21;
    localparam int CTAG1_W    = 10;

    typedef struct packed {
        in_req_t     req;
        logic [11:0] mag;
        logic        neg;
        logic [7:0]  ga;
        logic [7:0]  gb;
        logic [7:0]  num;
    } gcd_pipe_t;

    logic en;
    assign en = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = en;

    // stage 1: range check, magnitude, common factors of two
    in_req_t    rin;
    gcd_pipe_t  g1_next;
    logic [7:0] a_next;
    logic [7:0] b_next;
    logic       range_ok;

    assign rin = in_ch.data;

    always_comb
    begin
        range_ok = rin.first_step >= 8'd2 && rin.first_step < rin.second_step
            && {1'b0, rin.second_step} <= 9'(MAX_STEP);
        a_next = range_ok ? rin.first_step : 8'd1;
        b_next = range_ok ? rin.second_step : 8'd1;
        for (int i = 0; i < 8; i++)
        begin
            if (!a_next[0] && !b_next[0])
            begin
                a_next = {1'b0, a_next[7:1]};
                b_next = {1'b0, b_next[7:1]};
            end
        end
        g1_next.req = rin;
        g1_next.mag = rin.first_coef[11] ? 12'(-rin.first_coef) : 12'(rin.first_coef);
        g1_next.neg = rin.first_coef[11];
        g1_next.ga  = strip_twos(a_next);
        g1_next.gb  = b_next;
        g1_next.num = b_next;
    end

    logic      v1_reg;
    gcd_pipe_t p1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg <= g1_next;
        end
    end

    // stages 2..6: binary gcd of the odd-reduced step pair
    logic      gv [GCD_STAGES+1];
    gcd_pipe_t gp [GCD_STAGES+1];

    assign gv[0] = v1_reg;
    assign gp[0] = p1_reg;

    for (genvar s = 0; s < GCD_STAGES; s++)
    begin : g_gcd
        gcd_pipe_t p_next;
        logic      v_s_reg;
        gcd_pipe_t p_s_reg;

        always_comb
        begin
            logic [15:0] ab;
            ab = {gp[s].ga, gp[s].gb};
            for (int i = 0; i < GCD_ITERS; i++)
            begin
                ab = gcd_step(ab);
            end
            p_next    = gp[s];
            p_next.ga = ab[15:8];
            p_next.gb = ab[7:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_s_reg <= 1'b0;
            end
            else if (en)
            begin
                v_s_reg <= gv[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_s_reg <= p_next;
            end
        end

        assign gv[s+1] = v_s_reg;
        assign gp[s+1] = p_s_reg;
    end

    // stages 7..8: pair modulus, second step over gcd
    logic [7:0]        mq_raw;
    logic              mv;
    logic [MTAG_W-1:0] mtag_out;

    pqee_divider #(.NUM_W(8), .BITS_PER(4), .TAG_W(MTAG_W)) u_div_mod (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(gv[GCD_STAGES]),
        .num(gp[GCD_STAGES].num), .den(gp[GCD_STAGES].ga),
        .in_tag({gp[GCD_STAGES].req, gp[GCD_STAGES].mag, gp[GCD_STAGES].neg}),
        .out_valid(mv), .quot(mq_raw), .out_tag(mtag_out)
    );

    in_req_t     rm;
    logic [11:0] magm;
    logic        negm;
    logic [7:0]  m_eff;

    assign {rm, magm, negm} = mtag_out;
    assign m_eff = mq_raw[0] ? 8'd0 : mq_raw;

    // stages 9..11: magnitude over half the modulus
    logic [11:0]       hq;
    logic              hv;
    logic [HTAG_W-1:0] htag_out;

    pqee_divider #(.NUM_W(12), .BITS_PER(4), .TAG_W(HTAG_W)) u_div_half (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(mv), .num(magm),
        .den({1'b0, m_eff[7:1]}), .in_tag({rm, magm, negm, m_eff}),
        .out_valid(hv), .quot(hq), .out_tag(htag_out)
    );

    in_req_t     rh;
    logic [11:0] magh;
    logic        negh;
    logic [7:0]  mh;

    assign {rh, magh, negh, mh} = htag_out;

    // stage 12: odd multiple test and requantization numerator
    logic [6:0]       h_e;
    logic [18:0]      back_e;
    logic             el_next;
    logic [NUM_W-1:0] prod_next;

    always_comb
    begin
        h_e       = mh[7:1];
        back_e    = 19'(hq) * 19'(h_e);
        el_next   = rh.freq_index != '0 && mh != 8'd0 && back_e == 19'(magh) && hq[0];
        prod_next = NUM_W'(magh) * NUM_W'(rh.first_step);
    end

    logic             ve_reg;
    in_req_t          re_reg;
    logic [7:0]       me_reg;
    logic             ele_reg;
    logic             nege_reg;
    logic [NUM_W-1:0] prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ve_reg <= 1'b0;
        end
        else if (en)
        begin
            ve_reg <= hv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            re_reg   <= rh;
            me_reg   <= mh;
            ele_reg  <= el_next;
            nege_reg <= negh;
            prod_reg <= prod_next;
        end
    end

    // stages 13..17: bit-0 and bit-1 candidates
    logic [NUM_W-1:0]   n1_e;
    logic [NUM_W-1:0]   c0_q;
    logic [NUM_W-1:0]   c1_q;
    logic               dv0;
    logic               dv1;
    in_req_t            rq;
    logic [CTAG1_W-1:0] tag1_out;

    assign n1_e = prod_reg + NUM_W'(re_reg.second_step[7:1]);

    pqee_divider #(.NUM_W(NUM_W), .BITS_PER(4), .TAG_W($bits(in_req_t))) u_div0 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(ve_reg), .num(prod_reg),
        .den(re_reg.second_step), .in_tag(re_reg),
        .out_valid(dv0), .quot(c0_q), .out_tag(rq)
    );

    pqee_divider #(.NUM_W(NUM_W), .BITS_PER(4), .TAG_W(CTAG1_W)) u_div1 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(ve_reg), .num(n1_e),
        .den(re_reg.second_step), .in_tag({me_reg, ele_reg, nege_reg}),
        .out_valid(dv1), .quot(c1_q), .out_tag(tag1_out)
    );

    // stage 18: candidate matching
    logic [7:0] mq;
    logic       elq;
    logic       negq;
    coef_t      c0;
    coef_t      c1;
    out_req_t   res_next;

    assign {mq, elq, negq} = tag1_out;

    always_comb
    begin
        c0 = negq ? 12'(-c0_q[11:0]) : c0_q[11:0];
        c1 = negq ? 12'(-c1_q[11:0]) : c1_q[11:0];
        res_next = '0;
        res_next.pair_modulus = mq[6:0];
        if (elq)
        begin
            res_next.eligible      = 1'b1;
            res_next.embedded_coef = rq.message_bit ? c1 : c0;
            if (c0 == c1)
            begin
                res_next.ambiguous = 1'b1;
            end
            else if (rq.received_coef == c0)
            begin
                res_next.bit_found = 1'b1;
            end
            else if (rq.received_coef == c1)
            begin
                res_next.bit_found = 1'b1;
                res_next.found_bit = 1'b1;
            end
        end
    end

    logic     ov_reg;
    out_req_t od_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            ov_reg <= dv0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            od_reg <= res_next;
        end
    end

    assign out_ch.valid = ov_reg;
    assign out_ch.data  = od_reg;

    ap_div_sync: assert property (@(posedge clk) disable iff (!rst_n) dv0 == dv1)
        else $error("divider valid bits diverged");
    ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> $stable(out_ch.data) && out_ch.valid)
        else $error("stalled result changed");
    ap_amb: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !(out_ch.data.ambiguous && out_ch.data.bit_found))
        else $error("ambiguous and found together");
    ap_elig: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.data.eligible |-> out_ch.data.pair_modulus != '0)
        else $error("eligible with zero modulus");
endmodule : pq_coefficient_embed_extract_core
`default_nettype wire
